// ===== rtl/ntia_pkg.sv =====
// Shared constants, types and helpers for the nearest track ID assigner.
package ntia_pkg;

	// Table size and ID width
	localparam int NUM_TRACKS = 4;
	localparam int ID_BITS    = 16;

	localparam int IDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
	localparam int NV_W  = $clog2(NUM_TRACKS + 1);
	localparam int CNT_W = (NV_W > 4) ? NV_W : 4;

	// Configuration port
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_GATE  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_DELAY = 1'b1;

	localparam logic [31:0] GATE_RESET  = 32'd250000;
	localparam logic [15:0] DELAY_RESET = 16'd2000;

	// Result status codes
	localparam logic [1:0] ST_MATCH   = 2'd0;
	localparam logic [1:0] ST_NEW     = 2'd1;
	localparam logic [1:0] ST_CLEARED = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [IDX_W-1:0]   idx_t;

	typedef struct packed {
		logic [31:0] gate_dist_sq;
		logic [15:0] prune_delay_ms;
	} cfg_t;

	// Low 16 bits of an ID, zero-extended when IDs are narrower
	function automatic logic [15:0] to_track_id(input id_t id);
		logic [31:0] w;
		w = 32'(id);
		return w[15:0];
	endfunction

endpackage

// ===== rtl/ntia_if.sv =====
// Measurement and result channel interfaces.
interface ntia_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic        [3:0]  person_count;
	logic        [31:0] now_ms;

	modport source (output valid, pos_x, pos_y, person_count, now_ms, input ready);
	modport sink   (input valid, pos_x, pos_y, person_count, now_ms, output ready);
endinterface

interface ntia_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] track_id;
	logic [1:0]  status;

	modport source (output valid, track_id, status, input ready);
	modport sink   (input valid, track_id, status, output ready);
endinterface

// ===== rtl/ntia_sq_unit.sv =====
// Shared difference-squarer: one registered (a - b)^2 per cycle.
module ntia_sq_unit (
	input  logic               clk,
	input  logic signed [15:0] a,
	input  logic signed [15:0] b,
	output logic        [31:0] sq_s1
);
	logic signed [16:0] diff;
	logic signed [33:0] prod;

	// |a - b| <= 65535, so the square fits in 32 bits
	assign diff = 17'(a) - 17'(b);
	assign prod = diff * diff;

	always_ff @(posedge clk) begin
		sq_s1 <= prod[31:0];
	end
endmodule

// ===== rtl/ntia_cfg.sv =====
// APB-style configuration registers: gate distance and pruning delay.
module ntia_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ntia_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output ntia_pkg::cfg_t             cfg
);
	import ntia_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [31:0]          gate_q;
	logic [15:0]          delay_q;

	assign reg_idx = paddr[2 +: REG_IDX_W];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q  <= GATE_RESET;
			delay_q <= DELAY_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GATE:  gate_q  <= pwdata;
				REG_DELAY: delay_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_GATE:  prdata = gate_q;
			REG_DELAY: prdata = {16'd0, delay_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign cfg.gate_dist_sq   = gate_q;
	assign cfg.prune_delay_ms = delay_q;
endmodule

// ===== rtl/nearest_track_id_assigner.sv =====
// Items are accepted only while idle, so the block works on one item at a time.
// When the pruning timer has expired, an age scan and a prune step precede the
// distance scan; a zero count clears every entry instead. The distance scan runs
// through the single shared squarer in states S_SQX, S_SQY and S_ACC per table entry.
// Reset (asynchronous, active low) empties the table, IDs restart at the entry
// index and the registers return to gate 250000 mm^2 and delay 2000 ms.
module nearest_track_id_assigner (
	input  logic                        clk,
	input  logic                        arst_n,
	ntia_in_if.sink                     meas,
	ntia_out_if.source                  res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ntia_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import ntia_pkg::*;

	// Sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_PRE  = 4'd2;
	localparam logic [3:0] S_TMR  = 4'd3;
	localparam logic [3:0] S_AGE  = 4'd4;
	localparam logic [3:0] S_PRN  = 4'd5;
	localparam logic [3:0] S_SQX  = 4'd6;
	localparam logic [3:0] S_SQY  = 4'd7;
	localparam logic [3:0] S_ACC  = 4'd8;
	localparam logic [3:0] S_SEL  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	localparam idx_t LAST_IDX = IDX_W'(NUM_TRACKS - 1);

	cfg_t cfg;

	logic [3:0] state_q;
	idx_t       idx_q;

	// Latched item
	logic signed [15:0] px_q;
	logic signed [15:0] py_q;
	logic [3:0]         count_q;
	logic [31:0]        now_q;

	// Track table
	id_t                entry_id_q    [NUM_TRACKS];
	logic signed [15:0] entry_x_q     [NUM_TRACKS];
	logic signed [15:0] entry_y_q     [NUM_TRACKS];
	logic               entry_valid_q [NUM_TRACKS];
	logic [31:0]        entry_time_q  [NUM_TRACKS];
	id_t                fresh_id_q;

	// Pruning timer
	logic [3:0]  last_count_q;
	logic        prune_active_q;
	logic [7:0]  prune_pending_q;
	logic [31:0] prune_start_q;

	// Scan registers
	logic [CNT_W-1:0] nv_q;
	logic             oldest_found_q;
	idx_t             oldest_q;
	logic [31:0]      oldest_age_q;
	logic [31:0]      acc_q;
	logic             best_found_q;
	idx_t             best_q;
	logic [32:0]      best_d_q;
	logic             free_found_q;
	idx_t             free_q;

	// Pending and output result
	logic [15:0] pend_id_q;
	logic [1:0]  pend_status_q;
	logic        res_valid_q;
	logic [15:0] res_id_q;
	logic [1:0]  res_status_q;

	logic signed [15:0] sq_a;
	logic signed [15:0] sq_b;
	logic [31:0]        sq_s1;
	logic [32:0]        dist_sum;
	logic [31:0]        age;
	logic               expired;
	logic               sel_hit;
	idx_t               sel_idx;
	logic [1:0]         sel_status;
	logic               accept;

	ntia_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Operand select for the shared squarer: x pass, then y pass
	assign sq_a = (state_q == S_SQX) ? entry_x_q[idx_q] : entry_y_q[idx_q];
	assign sq_b = (state_q == S_SQX) ? px_q : py_q;

	ntia_sq_unit u_sq (
		.clk   (clk),
		.a     (sq_a),
		.b     (sq_b),
		.sq_s1 (sq_s1)
	);

	assign dist_sum = {1'b0, acc_q} + {1'b0, sq_s1};
	assign age      = now_q - entry_time_q[idx_q];
	assign expired  = prune_active_q && ((now_q - prune_start_q) > {16'd0, cfg.prune_delay_ms});

	assign meas.ready   = (state_q == S_IDLE);
	assign accept       = meas.valid && meas.ready;
	assign res.valid    = res_valid_q;
	assign res.track_id = res_id_q;
	assign res.status   = res_status_q;

	// Entry choice after the scan
	always_comb begin
		sel_hit    = 1'b0;
		sel_idx    = best_q;
		sel_status = ST_MATCH;
		priority if (best_found_q && (best_d_q < {1'b0, cfg.gate_dist_sq})) begin
			sel_hit = 1'b1;
		end else if (nv_q < CNT_W'(count_q)) begin
			sel_hit    = free_found_q;
			sel_idx    = free_q;
			sel_status = free_found_q ? ST_NEW : ST_FULL;
		end else begin
			sel_hit = best_found_q;
			if (!best_found_q) sel_status = ST_FULL;
		end
	end

	// Sequencer, table and timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			idx_q           <= '0;
			for (int i = 0; i < NUM_TRACKS; i++) begin
				entry_id_q[i]    <= ID_BITS'(i);
				entry_x_q[i]     <= '0;
				entry_y_q[i]     <= '0;
				entry_valid_q[i] <= 1'b0;
				entry_time_q[i]  <= '0;
			end
			fresh_id_q      <= ID_BITS'(NUM_TRACKS);
			last_count_q    <= '0;
			prune_active_q  <= 1'b0;
			prune_pending_q <= '0;
			prune_start_q   <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			// result taken; S_OUT reloads it itself
			if (res_valid_q && res.ready && (state_q != S_OUT)) res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (meas.person_count == 4'd0) begin
							last_count_q    <= '0;
							prune_active_q  <= 1'b0;
							prune_pending_q <= '0;
							state_q         <= S_CLR;
						end else begin
							state_q <= S_PRE;
						end
					end
				end
				// Free every entry under fresh IDs
				S_CLR: begin
					entry_id_q[idx_q]    <= fresh_id_q;
					fresh_id_q           <= fresh_id_q + 1'b1;
					entry_x_q[idx_q]     <= '0;
					entry_y_q[idx_q]     <= '0;
					entry_valid_q[idx_q] <= 1'b0;
					entry_time_q[idx_q]  <= now_q;
					idx_q                <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						pend_id_q     <= 16'd0;
						pend_status_q <= ST_CLEARED;
						state_q       <= S_OUT;
					end
				end
				// Count drop starts the timer
				S_PRE: begin
					if (count_q < last_count_q) begin
						if (!prune_active_q) prune_start_q <= now_q;
						prune_active_q <= 1'b1;
						if (prune_pending_q != 8'hFF) prune_pending_q <= prune_pending_q + 1'b1;
					end
					last_count_q <= count_q;
					state_q      <= S_TMR;
				end
				S_TMR: begin
					idx_q          <= '0;
					nv_q           <= '0;
					oldest_found_q <= 1'b0;
					state_q        <= expired ? S_AGE : S_SQX;
				end
				// Oldest valid entry, first on ties
				S_AGE: begin
					if (entry_valid_q[idx_q]) begin
						nv_q <= nv_q + 1'b1;
						if (!oldest_found_q || (age > oldest_age_q)) begin
							oldest_found_q <= 1'b1;
							oldest_q       <= idx_q;
							oldest_age_q   <= age;
						end
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) state_q <= S_PRN;
				end
				S_PRN: begin
					if (nv_q > CNT_W'(count_q)) begin
						entry_id_q[oldest_q]    <= fresh_id_q;
						fresh_id_q              <= fresh_id_q + 1'b1;
						entry_x_q[oldest_q]     <= '0;
						entry_y_q[oldest_q]     <= '0;
						entry_valid_q[oldest_q] <= 1'b0;
						entry_time_q[oldest_q]  <= now_q;
						if (prune_pending_q == 8'd0) prune_active_q <= 1'b0;
						else prune_pending_q <= prune_pending_q - 1'b1;
					end else begin
						prune_pending_q <= '0;
						prune_active_q  <= 1'b0;
					end
					idx_q   <= '0;
					nv_q    <= '0;
					state_q <= S_SQX;
				end
				S_SQX: begin
					if (idx_q == '0) begin
						best_found_q <= 1'b0;
						free_found_q <= 1'b0;
					end
					state_q <= S_SQY;
				end
				S_SQY: begin
					acc_q   <= sq_s1;
					state_q <= S_ACC;
				end
				// Nearest valid entry and first free entry
				S_ACC: begin
					if (entry_valid_q[idx_q]) begin
						nv_q <= nv_q + 1'b1;
						if (!best_found_q || (dist_sum < best_d_q)) begin
							best_found_q <= 1'b1;
							best_q       <= idx_q;
							best_d_q     <= dist_sum;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= idx_q;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q == LAST_IDX) ? S_SEL : S_SQX;
				end
				S_SEL: begin
					if (sel_hit) begin
						entry_x_q[sel_idx]     <= px_q;
						entry_y_q[sel_idx]     <= py_q;
						entry_valid_q[sel_idx] <= 1'b1;
						entry_time_q[sel_idx]  <= now_q;
						pend_id_q              <= to_track_id(entry_id_q[sel_idx]);
					end else begin
						pend_id_q <= 16'd0;
					end
					pend_status_q <= sel_status;
					state_q       <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= meas.pos_x;
			py_q    <= meas.pos_y;
			count_q <= meas.person_count;
			now_q   <= meas.now_ms;
		end
		if ((state_q == S_OUT) && (!res_valid_q || res.ready)) begin
			res_id_q     <= pend_id_q;
			res_status_q <= pend_status_q;
		end
	end
endmodule

// ===== rtl/ntia_checker.sv =====
// Port-level checks on the track ID assigner, bound to the top level.
module ntia_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] track_id,
	input logic [1:0]  status
);
	import ntia_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// The block works on one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready high in the cycle after an item was accepted");

	// No result is produced in the cycle after acceptance
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !out_valid |=> !out_valid)
		else $error("result appeared straight after acceptance");

	// Cleared and full results carry no ID
	a_no_id_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_CLEARED) || (status == ST_FULL)) |-> (track_id == 16'd0))
		else $error("non-zero track ID with cleared or full status");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(track_id) && $stable(status))
		else $error("stalled result changed");
endmodule

bind nearest_track_id_assigner ntia_checker u_ntia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (meas.valid),
	.in_ready  (meas.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.track_id  (res.track_id),
	.status    (res.status)
);
